>>> hdl/sprite_transform_mapper_macros.svh
// Assertion macros shared by the sprite transform mapper RTL.
`ifndef SPRITE_TRANSFORM_MAPPER_MACROS_SVH
`define SPRITE_TRANSFORM_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/stm_pkg.sv
// Types, codes and constants of the sprite transform mapper.
`default_nettype none

package stm_pkg;

    // Board size and run length limit.
    localparam int BOARD_WIDTH  = 64;
    localparam int BOARD_HEIGHT = 48;
    localparam int MAX_FACTOR   = 15;

    // Width of the signed coordinate arithmetic.
    localparam int CW = 16;

    // Transform mode codes.
    localparam logic [3:0] MODE_IDENT     = 4'd0;
    localparam logic [3:0] MODE_MIRROR_H  = 4'd1;
    localparam logic [3:0] MODE_MIRROR_V  = 4'd2;
    localparam logic [3:0] MODE_ROT_CW    = 4'd3;
    localparam logic [3:0] MODE_ROT_CCW   = 4'd4;
    localparam logic [3:0] MODE_STRETCH_H = 4'd5;
    localparam logic [3:0] MODE_STRETCH_V = 4'd6;
    localparam logic [3:0] MODE_SHEAR_H   = 4'd7;
    localparam logic [3:0] MODE_SHEAR_V   = 4'd8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_Y  = 3'd5;

    typedef logic signed [CW-1:0] t_coord;

    // One input item.
    typedef struct packed {
        logic [5:0] src_x;
        logic [5:0] src_y;
        logic       pixel_in;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [5:0] dst_x;
        logic [5:0] dst_y;
        logic       pixel_out;
        logic       off_board;
        logic       last_of_run;
    } t_result;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]        mode;
        logic signed [4:0] factor;
        logic [6:0]        sprite_width;
        logic [6:0]        sprite_height;
        logic signed [6:0] board_x;
        logic signed [6:0] board_y;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/stm_chan_if.sv
// Valid/ready channel interface carrying one item per handshake.
`default_nettype none

interface stm_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/stm_map.sv
// Coordinate transform of one source pixel for one position of its run.
`default_nettype none

module stm_map #(
    parameter int MAX_FACTOR = stm_pkg::MAX_FACTOR,
    parameter int KW         = $clog2(MAX_FACTOR + 1)
) (
    input  wire stm_pkg::t_item   i_item,
    input  wire stm_pkg::t_cfg    i_cfg,
    input  wire logic [KW-1:0]    i_k,
    output stm_pkg::t_result      o_result
);

    stm_pkg::t_coord x, y, w, h, s, bx, by;
    stm_pkg::t_coord f_c, k_c;
    stm_pkg::t_coord mul_a, mul_b, prod;
    stm_pkg::t_coord dx, dy, dx_b, dy_b;
    logic [KW-1:0]   run_len;
    logic            is_stretch;
    logic            off;

    // Widen every operand to the signed coordinate width.
    always_comb begin
        x  = signed'(stm_pkg::CW'(i_item.src_x));
        y  = signed'(stm_pkg::CW'(i_item.src_y));
        w  = signed'(stm_pkg::CW'(i_cfg.sprite_width));
        h  = signed'(stm_pkg::CW'(i_cfg.sprite_height));
        s  = stm_pkg::CW'(i_cfg.factor);
        bx = stm_pkg::CW'(i_cfg.board_x);
        by = stm_pkg::CW'(i_cfg.board_y);
    end

    // Stretch run length: at least one, at most MAX_FACTOR.
    always_comb begin
        if (s < stm_pkg::t_coord'(1)) begin
            run_len = KW'(1);
        end else if (int'(s) > MAX_FACTOR) begin
            run_len = KW'(MAX_FACTOR);
        end else begin
            run_len = KW'(s[3:0]);
        end
        f_c = signed'(stm_pkg::CW'(run_len));
        k_c = signed'(stm_pkg::CW'(i_k));
        is_stretch = (i_cfg.mode == stm_pkg::MODE_STRETCH_H) ||
                     (i_cfg.mode == stm_pkg::MODE_STRETCH_V);
    end

    // One shared multiplier serves stretch and shear.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cfg.mode)
            stm_pkg::MODE_STRETCH_H: begin
                mul_a = x;
                mul_b = f_c;
            end
            stm_pkg::MODE_STRETCH_V: begin
                mul_a = y;
                mul_b = f_c;
            end
            stm_pkg::MODE_SHEAR_H: begin
                if (s > 0) begin
                    mul_a = h - 1 - y;
                    mul_b = s;
                end else begin
                    mul_a = y;
                    mul_b = -s;
                end
            end
            stm_pkg::MODE_SHEAR_V: begin
                if (s > 0) begin
                    mul_a = w - 1 - x;
                    mul_b = s;
                end else begin
                    mul_a = x;
                    mul_b = -s;
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Destination within the sprite's own frame; unused codes act as identity.
    always_comb begin
        dx = x;
        dy = y;
        case (i_cfg.mode)
            stm_pkg::MODE_MIRROR_H:  dx = w - 1 - x;
            stm_pkg::MODE_MIRROR_V:  dy = h - 1 - y;
            stm_pkg::MODE_ROT_CW: begin
                dx = h - 1 - y;
                dy = x;
            end
            stm_pkg::MODE_ROT_CCW: begin
                dx = y;
                dy = w - 1 - x;
            end
            stm_pkg::MODE_STRETCH_H: dx = prod + k_c;
            stm_pkg::MODE_STRETCH_V: dy = prod + k_c;
            stm_pkg::MODE_SHEAR_H:   dx = x + prod;
            stm_pkg::MODE_SHEAR_V:   dy = y + prod;
            default: begin
                dx = x;
                dy = y;
            end
        endcase
    end

    // Board placement, clipping and the end-of-run mark.
    always_comb begin
        dx_b = dx + bx;
        dy_b = dy + by;
        off  = (dx_b < 0) || (dx_b >= stm_pkg::t_coord'(stm_pkg::BOARD_WIDTH)) ||
               (dy_b < 0) || (dy_b >= stm_pkg::t_coord'(stm_pkg::BOARD_HEIGHT));
        o_result.dst_x       = off ? 6'd0 : dx_b[5:0];
        o_result.dst_y       = off ? 6'd0 : dy_b[5:0];
        o_result.pixel_out   = i_item.pixel_in;
        o_result.off_board   = off;
        o_result.last_of_run = is_stretch ? (i_k == KW'(run_len - KW'(1))) : 1'b1;
    end

endmodule

`default_nettype wire

>>> hdl/sprite_transform_mapper.sv
// Top level of the sprite transform mapper: input stage, run counter, result register.
// One input item (a sprite pixel with its source column and row) is taken per cycle and
// gives one result item through an input register and a result register. In the two
// stretch modes an item gives a run of factor results (1 to MAX_FACTOR), one per cycle,
// and holds the input stage until its run ends; every other mode sustains one item per
// cycle. Both rates hold unless results stall. The last result of every item carries
// last_of_run; results off the 64 by 48 board have off_board set, zero coordinates. The
// user must write configuration registers only while no item is in flight (unenforced).
`default_nettype none
`include "sprite_transform_mapper_macros.svh"

module sprite_transform_mapper #(
    parameter int MAX_FACTOR = stm_pkg::MAX_FACTOR
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [stm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [stm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    stm_chan_if.sink                              i_item,
    stm_chan_if.source                            o_result
);

    localparam int KW = $clog2(MAX_FACTOR + 1);

    stm_pkg::t_cfg    r_cfg;
    stm_pkg::t_item   r_item;
    logic             r_in_valid;
    logic [KW-1:0]    r_k;
    stm_pkg::t_result r_out;
    logic             r_out_valid;

    stm_pkg::t_result map_res;
    logic             out_load;
    logic             retire;
    logic             in_accept;
    logic             is_stretch;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= stm_pkg::MODE_IDENT;
            r_cfg.factor        <= 5'sd1;
            r_cfg.sprite_width  <= 7'd5;
            r_cfg.sprite_height <= 7'd7;
            r_cfg.board_x       <= '0;
            r_cfg.board_y       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stm_pkg::REG_MODE:    r_cfg.mode          <= i_cfg_data[3:0];
                stm_pkg::REG_FACTOR:  r_cfg.factor        <= signed'(i_cfg_data[4:0]);
                stm_pkg::REG_WIDTH:   r_cfg.sprite_width  <= i_cfg_data;
                stm_pkg::REG_HEIGHT:  r_cfg.sprite_height <= i_cfg_data;
                stm_pkg::REG_BOARD_X: r_cfg.board_x       <= signed'(i_cfg_data);
                stm_pkg::REG_BOARD_Y: r_cfg.board_y       <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Transform of the item held in the input stage at run position r_k.
    stm_map #(
        .MAX_FACTOR (MAX_FACTOR),
        .KW         (KW)
    ) u_map (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_k      (r_k),
        .o_result (map_res)
    );

    // Handshake control: a result moves on when the result register is free or drained.
    always_comb begin
        out_load       = r_in_valid && (!r_out_valid || o_result.ready);
        retire         = out_load && map_res.last_of_run;
        i_item.ready   = !r_in_valid || retire;
        in_accept      = i_item.valid && i_item.ready;
        is_stretch     = (r_cfg.mode == stm_pkg::MODE_STRETCH_H) ||
                         (r_cfg.mode == stm_pkg::MODE_STRETCH_V);
        o_result.valid = r_out_valid;
        o_result.data  = r_out;
    end

    // Input stage and run counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_k        <= '0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
            r_k        <= '0;
        end else if (retire) begin
            r_in_valid <= 1'b0;
        end else if (out_load) begin
            r_k <= r_k + KW'(1);
        end
    end

    // Input payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_item.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= map_res;
        end
    end

    // A freshly accepted item starts its run at position zero.
    `STM_ASSERT_NEXT(a_accept_starts_run, i_clk, i_rst_n, in_accept, r_in_valid && (r_k == '0))
    // An item that has not given its last result stays in the input stage.
    `STM_ASSERT_NEXT(a_item_held, i_clk, i_rst_n, r_in_valid && !retire, r_in_valid)
    // Outside the stretch modes every result closes its run.
    `STM_ASSERT_SAME(a_single_result, i_clk, i_rst_n, out_load && !is_stretch, retire)
    // A clipped result carries zero coordinates.
    `STM_ASSERT_SAME(a_clip_zero, i_clk, i_rst_n, r_out_valid && r_out.off_board, (r_out.dst_x == 6'd0) && (r_out.dst_y == 6'd0))

endmodule

`default_nettype wire

>>> bench/sprite_transform_mapper_tb.sv
// Self-checking testbench for the sprite transform mapper: directed and random pixel streams.
`default_nettype none

module sprite_transform_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stm_pkg::*;

    // Register indexes past the end of the register list; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // Mode codes past the defined transforms; they behave as identity.
    localparam logic [3:0] MODE_SPARE_LO = 4'd9;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam int CLK_HALF_NS   = 6;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 250;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_PIXELS  = 13;
    localparam int PRESSURE_PHASE = 4;
    localparam int MAX_REPORTS   = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stm_chan_if #(.t_payload(t_item))   item_if ();
    stm_chan_if #(.t_payload(t_result)) result_if ();

    sprite_transform_mapper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // Shadow copy of the configuration registers.
    logic [3:0]        cfg_mode;
    logic signed [4:0] cfg_factor;
    logic [6:0]        cfg_width;
    logic [6:0]        cfg_height;
    logic signed [6:0] cfg_board_x;
    logic signed [6:0] cfg_board_y;

    t_item   pending_pixels[$];
    t_result expected_results[$];

    int  err_count;
    int  items_sent;
    int  results_checked;
    int  settings_used;
    int  tx_gap;
    int  rx_stall;
    int  rx_pick;
    int  hold_left;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_trigger;
    bit  hold_seen;

    // Clock generation.
    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Counts one mismatch and prints a line for the first MAX_REPORTS of them.
    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        end
    endtask

    // Gap or stall length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Queues one board write, clipping it against the board.
    task automatic push_board_write(input int dx, input int dy, input logic pix,
                                    input bit last);
        t_result r;
        bit      off;
        off = (dx < 0) || (dx >= BOARD_WIDTH) || (dy < 0) || (dy >= BOARD_HEIGHT);
        r.dst_x       = off ? 6'd0 : dx[5:0];
        r.dst_y       = off ? 6'd0 : dy[5:0];
        r.pixel_out   = pix;
        r.off_board   = off;
        r.last_of_run = last;
        expected_results.push_back(r);
    endtask

    // Works out the board writes that one source pixel causes.
    task automatic map_pixel(input t_item it);
        int x, y, w, h, s, bx, by, dx, dy, f;
        x  = it.src_x;
        y  = it.src_y;
        w  = cfg_width;
        h  = cfg_height;
        s  = cfg_factor;
        bx = cfg_board_x;
        by = cfg_board_y;
        dx = x;
        dy = y;
        case (cfg_mode)
            MODE_MIRROR_H: begin
                dx = w - 1 - x;
            end
            MODE_MIRROR_V: begin
                dy = h - 1 - y;
            end
            MODE_ROT_CW: begin
                dx = h - 1 - y;
                dy = x;
            end
            MODE_ROT_CCW: begin
                dx = y;
                dy = w - 1 - x;
            end
            MODE_STRETCH_H, MODE_STRETCH_V: begin
                // A factor below one still gives a single write.
                f = (s < 1) ? 1 : s;
                if (f > MAX_FACTOR) begin
                    f = MAX_FACTOR;
                end
                for (int k = 0; k < f; k++) begin
                    if (cfg_mode == MODE_STRETCH_H) begin
                        push_board_write(x * f + k + bx, y + by, it.pixel_in, k == f - 1);
                    end else begin
                        push_board_write(x + bx, y * f + k + by, it.pixel_in, k == f - 1);
                    end
                end
                return;
            end
            MODE_SHEAR_H: begin
                dx = (s > 0) ? x + (h - 1 - y) * s : x + y * (-s);
            end
            MODE_SHEAR_V: begin
                dy = (s > 0) ? y + (w - 1 - x) * s : y + x * (-s);
            end
            default: begin
            end
        endcase
        push_board_write(dx + bx, dy + by, it.pixel_in, 1'b1);
    endtask

    // Compares one result item against the oldest expectation.
    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.dst_x !== want.dst_x) begin
            report_mismatch($sformatf("dst_x %0d, expected %0d", got.dst_x, want.dst_x));
        end
        if (got.dst_y !== want.dst_y) begin
            report_mismatch($sformatf("dst_y %0d, expected %0d", got.dst_y, want.dst_y));
        end
        if (got.pixel_out !== want.pixel_out) begin
            report_mismatch($sformatf("pixel_out %b, expected %b",
                                      got.pixel_out, want.pixel_out));
        end
        if (got.off_board !== want.off_board) begin
            report_mismatch($sformatf("off_board %b, expected %b",
                                      got.off_board, want.off_board));
        end
        if (got.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      got.last_of_run, want.last_of_run));
        end
    endtask

    // Item driver: offers queued pixels with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                map_pixel(item_if.data);
                items_sent++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap        <= tx_gap - 1;
                    item_if.valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    item_if.valid <= 1'b1;
                    item_if.data  <= pending_pixels.pop_front();
                    tx_gap        <= pick_gap(tx_idle_en);
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by a toggle of hold_trigger.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks accepted results and stalls ready at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            rx_stall        <= 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                check_result(result_if.data);
            end
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall        <= rx_stall - 1;
                result_if.ready <= 1'b0;
            end else begin
                rx_pick = pick_gap(rx_idle_en);
                result_if.ready <= (rx_pick == 0);
                rx_stall        <= (rx_pick > 0) ? rx_pick - 1 : 0;
            end
        end
    end

    // Writes one register and keeps the shadow copy in step.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_MODE:    cfg_mode    = val[3:0];
            REG_FACTOR:  cfg_factor  = val[4:0];
            REG_WIDTH:   cfg_width   = val;
            REG_HEIGHT:  cfg_height  = val;
            REG_BOARD_X: cfg_board_x = val;
            REG_BOARD_Y: cfg_board_y = val;
            default: begin
            end
        endcase
    endtask

    // Writes the whole register set.
    task automatic set_all(input logic [3:0] m, input int f, input int w, input int h,
                           input int bx, input int by);
        set_reg(REG_MODE, {3'b000, m});
        set_reg(REG_FACTOR, {2'b00, f[4:0]});
        set_reg(REG_WIDTH, w[6:0]);
        set_reg(REG_HEIGHT, h[6:0]);
        set_reg(REG_BOARD_X, bx[6:0]);
        set_reg(REG_BOARD_Y, by[6:0]);
        settings_used++;
    endtask

    // Changes only the mode and factor.
    task automatic set_transform(input logic [3:0] m, input int f);
        set_reg(REG_MODE, {3'b000, m});
        set_reg(REG_FACTOR, {2'b00, f[4:0]});
        settings_used++;
    endtask

    task automatic queue_pixel(input int x, input int y, input bit pix);
        t_item it;
        it.src_x    = x[5:0];
        it.src_y    = y[5:0];
        it.pixel_in = pix;
        pending_pixels.push_back(it);
    endtask

    // Waits until every pixel has gone in and every result has come back.
    task automatic settle();
        int quiet;
        int waited;
        quiet  = 0;
        waited = 0;
        while (quiet < 4 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
            if (pending_pixels.size() == 0 && !item_if.valid && expected_results.size() == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
        if (quiet < 4) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
            expected_results.delete();
        end
    endtask

    // Random source coordinate, mostly inside the sprite.
    function automatic int pick_coord(input int extent);
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, extent - 1);
        end
        return $urandom_range(0, 63);
    endfunction

    // Stimulus: directed corners first, then random register settings and pixels.
    initial begin
        logic [3:0] m;
        int         w, h;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        hold_trigger    = 1'b0;
        err_count       = 0;
        items_sent      = 0;
        results_checked = 0;
        settings_used   = 1;
        cfg_mode        = MODE_IDENT;
        cfg_factor      = 5'sd1;
        cfg_width       = 7'd5;
        cfg_height      = 7'd7;
        cfg_board_x     = '0;
        cfg_board_y     = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: identity on a 5 by 7 sprite at the board origin.
        queue_pixel(0, 0, 1);
        queue_pixel(4, 6, 0);
        queue_pixel(63, 63, 1);
        settle();

        // Mirrors with 64 by 1 and 1 by 64 sprites and board offsets at their extremes.
        set_all(MODE_MIRROR_H, 1, 64, 1, -64, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(63, 0, 0);
        settle();
        set_all(MODE_MIRROR_V, 1, 1, 64, 63, -64);
        queue_pixel(0, 0, 1);
        queue_pixel(1, 63, 0);
        settle();

        // Rotations.
        set_all(MODE_ROT_CW, 1, 5, 7, 0, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(5, 6, 0);
        settle();
        set_transform(MODE_ROT_CCW, 1);
        queue_pixel(0, 0, 1);
        queue_pixel(4, 3, 1);
        settle();

        // Stretches: largest factor, zero and a negative factor acting as one.
        set_transform(MODE_STRETCH_H, 15);
        queue_pixel(3, 2, 1);
        settle();
        set_transform(MODE_STRETCH_H, 0);
        queue_pixel(63, 0, 1);
        settle();
        set_transform(MODE_STRETCH_V, -15);
        queue_pixel(2, 5, 1);
        settle();
        set_transform(MODE_STRETCH_V, 3);
        queue_pixel(2, 5, 0);
        settle();

        // Shears with positive and negative factors.
        set_transform(MODE_SHEAR_H, 15);
        queue_pixel(1, 1, 1);
        settle();
        set_transform(MODE_SHEAR_H, -15);
        queue_pixel(2, 3, 0);
        settle();
        set_transform(MODE_SHEAR_V, 3);
        queue_pixel(0, 2, 1);
        settle();
        set_transform(MODE_SHEAR_V, -1);
        queue_pixel(5, 5, 1);
        settle();

        // Writes past the register list change nothing; spare mode codes act as identity.
        set_reg(REG_SPARE_A, 7'h7F);
        set_reg(REG_SPARE_B, 7'h55);
        set_transform(MODE_SPARE_LO, 2);
        queue_pixel(7, 8, 1);
        settle();
        set_transform(MODE_SPARE_HI, -2);
        queue_pixel(62, 1, 0);
        settle();

        // Random register settings, each with a burst of pixels.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if ($urandom_range(0, 9) == 0) begin
                m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            end else begin
                m = 4'($urandom_range(MODE_IDENT, MODE_SHEAR_V));
            end
            if (ph == 0) begin
                set_all(m, $urandom_range(0, 30) - 15, 64, 64, -64, -64);
            end else if (ph == 1) begin
                set_all(m, $urandom_range(0, 30) - 15, 1, 1, 63, 63);
            end else begin
                set_all(m, $urandom_range(0, 30) - 15, $urandom_range(1, 64),
                        $urandom_range(1, 64), $urandom_range(0, 127) - 64,
                        $urandom_range(0, 127) - 64);
            end
            w = cfg_width;
            h = cfg_height;
            // Some phases run without any idling on either side.
            @(posedge i_clk);
            tx_idle_en <= (ph % 3 != 2);
            rx_idle_en <= (ph % 3 != 2) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                queue_pixel(pick_coord(w), pick_coord(h), 1'($urandom_range(0, 1)));
            end
            // Hold results back while pixels keep coming, so the input backs up.
            if (ph == PRESSURE_PHASE) begin
                @(posedge i_clk);
                hold_trigger <= ~hold_trigger;
            end
            settle();
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d pixel items and %0d results over %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("It took in every transform, spare modes, factor extremes and a long hold-off.");
        if (err_count == 0) begin
            $display("sprite_transform_mapper_tb passed");
        end else begin
            $display("sprite_transform_mapper_tb failed");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("sprite_transform_mapper_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
